// File: sv/wcts_pkg.sv
// shared types, widths and codes for the weighted class transition sampler
// no dependencies; used by wcts_ctrl, wcts_dp and the top level
package wcts_pkg;

    // table geometry
    localparam int MAX_CLASSES = 16;
    localparam int CLS_W       = $clog2(MAX_CLASSES);
    localparam int COL_W       = $clog2(MAX_CLASSES + 1);
    localparam int ADDR_W      = 2 * CLS_W;
    localparam int DEPTH       = MAX_CLASSES * MAX_CLASSES;

    // field widths
    localparam int OP_W     = 1;
    localparam int FCLS_W   = 4;
    localparam int PROB_W   = 16;
    localparam int PIX_W    = 16;
    localparam int POT_W    = 16;
    localparam int POT_FRAC = 8;
    localparam int RND_W    = 16;
    localparam int STAT_W   = 2;

    // configuration port
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [COUNT_W-1:0] CLASS_COUNT_RESET = 5'd5;

    // arithmetic widths: weighted term Q7.24, running sum, and r * total
    localparam int TERM_W     = PROB_W + POT_W - 1;
    localparam int ACC_W      = TERM_W + CLS_W;
    localparam int SPLIT      = ACC_W / 2;
    localparam int LO_PROD_W  = RND_W + SPLIT;
    localparam int HI_PROD_W  = RND_W + ACC_W - SPLIT;
    localparam int LHS_W      = ACC_W + RND_W;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_SAMPLED = 2'd0;
    localparam logic [STAT_W-1:0] ST_NODATA  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOPOT   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE  = 2'd2;

    typedef struct packed {
        logic                    operation;
        logic [FCLS_W-1:0]       src_class;
        logic [FCLS_W-1:0]       dst_class;
        logic [PROB_W-1:0]       probability;
        logic signed [PIX_W-1:0] pixel_class;
        logic signed [POT_W-1:0] potential;
        logic [RND_W-1:0]        random_value;
    } item_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] new_class;
        logic [STAT_W-1:0]       status;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             load_wr;
        logic             rd_issue;
        logic [CLS_W-1:0] rd_col;
        logic             pass_sel;
        logic             acc_clear;
        logic             mul_lo;
        logic             mul_hi;
        logic             out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             bypass;
        logic             total_zero;
        logic             slot_free;
        logic [COL_W-1:0] eff_count;
    } stat_t;

endpackage

// File: sv/wcts_ctrl.sv
// sequencer for the sampler: load beats, bypass checks, total and select passes
// depends on wcts_pkg
module wcts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            operation,
    output logic            item_stall,
    output wcts_pkg::cmd_t  cmd,
    input  wcts_pkg::stat_t stat
);

    localparam int COL_W = wcts_pkg::COL_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_SUM       = 4'd2;
    localparam logic [3:0] S_SUM_DRAIN = 4'd3;
    localparam logic [3:0] S_MUL_LO    = 4'd4;
    localparam logic [3:0] S_MUL_HI    = 4'd5;
    localparam logic [3:0] S_SEL       = 4'd6;
    localparam logic [3:0] S_SEL_DRAIN = 4'd7;
    localparam logic [3:0] S_RESULT    = 4'd8;

    // pipeline from read issue to accumulator (read data, term) is drained once drain_reg reaches DRAIN_LAST
    localparam logic DRAIN_LAST = 1'b1;

    logic [3:0]       state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             drain_reg, drain_next;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        drain_next = drain_reg;
        cmd        = '0;
        cmd.rd_col = col_reg[wcts_pkg::CLS_W-1:0];
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (operation == wcts_pkg::OP_PIXEL)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_CHECK;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.bypass)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.acc_clear = 1'b1;
                    col_next      = '0;
                    state_next    = S_SUM;
                end
            end
            S_SUM, S_SEL:
            begin
                cmd.rd_issue = 1'b1;
                cmd.pass_sel = (state_reg == S_SEL);
                col_next     = col_reg + COL_W'(1);
                if (col_reg == stat.eff_count - COL_W'(1))
                begin
                    drain_next = 1'b0;
                    state_next = (state_reg == S_SUM) ? S_SUM_DRAIN : S_SEL_DRAIN;
                end
            end
            S_SUM_DRAIN, S_SEL_DRAIN:
            begin
                cmd.pass_sel = (state_reg == S_SEL_DRAIN);
                drain_next   = 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = (state_reg == S_SUM_DRAIN) ? S_MUL_LO : S_RESULT;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = stat.total_zero ? S_RESULT : S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi    = 1'b1;
                cmd.acc_clear = 1'b1;
                col_next      = '0;
                state_next    = S_SEL;
            end
            S_RESULT:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    // a pixel beat always starts with the bypass check
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && item_valid && operation == wcts_pkg::OP_PIXEL)
        |=> (state_reg == S_CHECK))
        else $error("pixel beat did not enter check");

    // column walk never runs past the table row
    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(wcts_pkg::MAX_CLASSES))
        else $error("column counter past row end");

    // no item taken while a result is being produced
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT) |-> item_stall)
        else $error("item accepted while result pending");

endmodule

// File: sv/wcts_dp.sv
// datapath: configuration registers, transition table, weighting pipeline,
// running sum, r * total product and output register; depends on wcts_pkg
module wcts_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wcts_pkg::item_t                     item,
    input  wcts_pkg::cmd_t                      cmd,
    output wcts_pkg::stat_t                     stat,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wcts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wcts_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output wcts_pkg::result_t                   result
);

    localparam int CLS_W     = wcts_pkg::CLS_W;
    localparam int COL_W     = wcts_pkg::COL_W;
    localparam int ADDR_W    = wcts_pkg::ADDR_W;
    localparam int DEPTH     = wcts_pkg::DEPTH;
    localparam int PROB_W    = wcts_pkg::PROB_W;
    localparam int PIX_W     = wcts_pkg::PIX_W;
    localparam int POT_W     = wcts_pkg::POT_W;
    localparam int POT_FRAC  = wcts_pkg::POT_FRAC;
    localparam int RND_W     = wcts_pkg::RND_W;
    localparam int COUNT_W   = wcts_pkg::COUNT_W;
    localparam int TERM_W    = wcts_pkg::TERM_W;
    localparam int ACC_W     = wcts_pkg::ACC_W;
    localparam int SPLIT     = wcts_pkg::SPLIT;
    localparam int LO_PROD_W = wcts_pkg::LO_PROD_W;
    localparam int HI_PROD_W = wcts_pkg::HI_PROD_W;
    localparam int LHS_W     = wcts_pkg::LHS_W;

    // configuration
    logic [COUNT_W-1:0] class_count_reg;
    logic               nodata_en_reg;
    logic [PIX_W-1:0]   nodata_val_reg;
    logic [COL_W-1:0]   eff_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= wcts_pkg::CLASS_COUNT_RESET;
            nodata_en_reg   <= 1'b0;
            nodata_val_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                wcts_pkg::CFG_CLASS_COUNT:   class_count_reg <= cfg_data[COUNT_W-1:0];
                wcts_pkg::CFG_NODATA_ENABLE: nodata_en_reg   <= cfg_data[0];
                wcts_pkg::CFG_NODATA_VALUE:  nodata_val_reg  <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign eff_count = (32'(class_count_reg) > wcts_pkg::MAX_CLASSES)
                     ? COL_W'(wcts_pkg::MAX_CLASSES) : COL_W'(class_count_reg);

    // pixel capture
    logic [PIX_W-1:0] pix_reg;
    logic [POT_W-1:0] pot_reg;
    logic [RND_W-1:0] rnd_reg;
    logic [CLS_W-1:0] cur_reg;
    logic [CLS_W-1:0] chosen_reg;
    logic             found_reg;

    // table: memory plus one valid bit per entry, unwritten entries read zero
    logic [PROB_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [PROB_W-1:0] rd_data_reg;
    logic              rd_ok_reg;

    assign wr_en = cmd.load_wr
                && (COL_W'(item.src_class) < eff_count)
                && (COL_W'(item.dst_class) < eff_count);
    assign wr_addr = {CLS_W'(item.src_class), CLS_W'(item.dst_class)};
    assign rd_addr = {cur_reg, cmd.rd_col};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item.probability;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= vld_reg[rd_addr];
        end
    end

    // weighting stage: own class is p << 8, others p * weight
    logic              a_tag_reg, b_tag_reg;
    logic [CLS_W-1:0]  a_col_reg, b_col_reg;
    logic [PROB_W-1:0] entry;
    logic [TERM_W-1:0] term_next, term_reg;

    assign entry     = rd_ok_reg ? rd_data_reg : '0;
    assign term_next = (a_col_reg == cur_reg)
                     ? TERM_W'({entry, {POT_FRAC{1'b0}}})
                     : TERM_W'(entry) * TERM_W'(pot_reg[POT_W-2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= 1'b0;
            b_tag_reg <= 1'b0;
        end
        else
        begin
            a_tag_reg <= cmd.rd_issue;
            b_tag_reg <= a_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_col_reg <= cmd.rd_col;
        b_col_reg <= a_col_reg;
        term_reg  <= term_next;
    end

    // running sum and first-hit search
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_sum;
    logic [LO_PROD_W-1:0] lo_reg;
    logic [HI_PROD_W-1:0] hi_reg;
    logic [LHS_W-1:0]     lhs_reg;
    logic                 hit;

    assign acc_sum = acc_reg + ACC_W'(term_reg);
    assign hit     = b_tag_reg && cmd.pass_sel && !found_reg
                  && (lhs_reg <= {acc_sum, {RND_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (b_tag_reg)
        begin
            acc_reg <= acc_sum;
        end
        if (cmd.mul_lo)
        begin
            lo_reg <= LO_PROD_W'(rnd_reg) * LO_PROD_W'(acc_reg[SPLIT-1:0]);
            hi_reg <= HI_PROD_W'(rnd_reg) * HI_PROD_W'(acc_reg[ACC_W-1:SPLIT]);
        end
        if (cmd.mul_hi)
        begin
            lhs_reg <= {hi_reg, {SPLIT{1'b0}}} + LHS_W'(lo_reg);
        end
        if (cmd.capture)
        begin
            pix_reg    <= item.pixel_class;
            pot_reg    <= item.potential;
            rnd_reg    <= item.random_value;
            cur_reg    <= item.pixel_class[CLS_W-1:0];
            chosen_reg <= item.pixel_class[CLS_W-1:0];
        end
        else if (hit)
        begin
            chosen_reg <= b_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            found_reg <= 1'b0;
        end
        else if (hit)
        begin
            found_reg <= 1'b1;
        end
    end

    // pass-through checks in priority order
    logic              nodata_hit, range_bad, no_pot, bypass;
    wcts_pkg::result_t res_next;
    wcts_pkg::result_t result_reg;
    logic              result_valid_reg;

    assign nodata_hit = nodata_en_reg && (pix_reg == nodata_val_reg);
    assign range_bad  = pix_reg[PIX_W-1] || (pix_reg >= PIX_W'(eff_count));
    assign no_pot     = pot_reg[POT_W-1] || (pot_reg == '0);
    assign bypass     = nodata_hit || range_bad || no_pot;

    always_comb
    begin
        if (nodata_hit)
        begin
            res_next.new_class = nodata_val_reg;
            res_next.status    = wcts_pkg::ST_NODATA;
        end
        else if (range_bad)
        begin
            res_next.new_class = pix_reg;
            res_next.status    = wcts_pkg::ST_RANGE;
        end
        else if (no_pot)
        begin
            res_next.new_class = pix_reg;
            res_next.status    = wcts_pkg::ST_NOPOT;
        end
        else
        begin
            res_next.new_class = PIX_W'(chosen_reg);
            res_next.status    = wcts_pkg::ST_SAMPLED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg <= res_next;
        end
    end

    assign result_valid    = result_valid_reg;
    assign result          = result_reg;
    assign stat.bypass     = bypass;
    assign stat.total_zero = (acc_reg == '0);
    assign stat.slot_free  = !result_valid_reg || !result_stall;
    assign stat.eff_count  = eff_count;

    // reads stay inside the active part of the row
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (COL_W'(cmd.rd_col) < eff_count))
        else $error("table read beyond class count");

    // a sampled class is always a class in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !bypass) |-> (COL_W'(chosen_reg) < eff_count))
        else $error("sampled class out of range");

endmodule

// File: sv/weighted_class_transition_sampler.sv
// top level of the weighted class transition sampler
// joins wcts_ctrl and wcts_dp; depends on wcts_pkg
//
// Holds a class-to-class transition table (MAX_CLASSES x MAX_CLASSES entries,
// Q0.16, zero after reset) and resamples pixel classes by roulette-wheel
// selection. A load beat (operation 0) writes one entry in the cycle it is
// taken and gives no result; loads outside the class count are dropped. A
// pixel beat (operation 1) gives exactly one result beat. Nodata, an
// out-of-range class and a potential of zero or less pass the class through
// with their status and no row walk. Otherwise the controller walks the
// pixel's table row twice through the single table read port, once to form
// the weighted total and once to find the first class whose running sum
// reaches random_value * total; a row whose total is zero keeps its class
// after the first walk. One pixel is in flight at a time; load beats are
// taken back to back. The result sits in an output register, so the next
// beat is taken while it waits to be drained. Configuration writes are
// always ready and are meant for idle periods only.
module weighted_class_transition_sampler (
    input  logic                             clk,
    input  logic                             rst_n,
    // item channel
    input  logic                             item_valid,
    output logic                             item_stall,
    input  wcts_pkg::item_t                  item,
    // result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output wcts_pkg::result_t                result,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wcts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wcts_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // command and status between sequencer and datapath
    wcts_pkg::cmd_t  cmd;
    wcts_pkg::stat_t stat;

    // sequencer: accepts beats, runs the two row passes and the product steps
    wcts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (item.operation),
        .item_stall (item_stall),
        .cmd        (cmd),
        .stat       (stat)
    );

    // datapath: registers, table memory, weighting pipeline and output beat
    wcts_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: tb/sv/weighted_class_transition_sampler_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the weighted class transition sampler
// depends on wcts_pkg and weighted_class_transition_sampler; needs nothing else

module weighted_class_transition_sampler_tb;

    // quiet cycles allowed before the run is declared hung; the slowest legal
    // gap is one sampled pixel plus long random stalls either side
    localparam int WATCHDOG_LIMIT = 4000;
    // cycles left after the last result before the block counts as idle;
    // covers a full sixteen-class pixel with margin
    localparam int SETTLE_CYCLES  = 64;
    localparam int REPORT_CAP     = 200;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    wcts_pkg::item_t   item_beat    = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    wcts_pkg::result_t result_beat;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [wcts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wcts_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // idling odds, in percent per cycle, for each side
    int send_idle_pct = 27;
    int recv_idle_pct = 82;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // predictor state: own copy of the table and the registers
    logic [wcts_pkg::PROB_W-1:0]  prob_table [wcts_pkg::DEPTH];
    logic [wcts_pkg::COUNT_W-1:0] cur_class_count = wcts_pkg::CLASS_COUNT_RESET;
    logic                         cur_nodata_en   = 1'b0;
    logic [wcts_pkg::PIX_W-1:0]   cur_nodata_val  = '0;

    // results still owed by the block, oldest first
    wcts_pkg::result_t pending_results [$];
    wcts_pkg::result_t head_result;

    weighted_class_transition_sampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        foreach (prob_table[i])
            prob_table[i] = '0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // class count in use; anything above the table size acts as the table size
    function automatic int eff_classes();
        return (cur_class_count > wcts_pkg::MAX_CLASSES) ? wcts_pkg::MAX_CLASSES
                                                         : int'(cur_class_count);
    endfunction

    // roulette-wheel pick over the weighted row, done without division:
    // first column with random * total <= running_sum * 2^16
    function automatic wcts_pkg::result_t predict_class(input wcts_pkg::item_t it);
        logic [63:0]                 run_sum [wcts_pkg::MAX_CLASSES];
        logic [63:0]                 total;
        logic [63:0]                 term;
        logic [63:0]                 weight;
        logic [63:0]                 scaled;
        logic [wcts_pkg::PROB_W-1:0] entry;
        int                          n;
        int                          cur;
        int                          j;
        bit                          found;
        wcts_pkg::result_t           res;
        n = eff_classes();
        res.new_class = it.pixel_class;
        res.status    = wcts_pkg::ST_SAMPLED;
        // nodata wins over every other check, even an out-of-range class
        if (cur_nodata_en && it.pixel_class == cur_nodata_val)
        begin
            res.new_class = cur_nodata_val;
            res.status    = wcts_pkg::ST_NODATA;
            return res;
        end
        if ($signed(it.pixel_class) < 0 || int'($signed(it.pixel_class)) >= n)
        begin
            res.status = wcts_pkg::ST_RANGE;
            return res;
        end
        if ($signed(it.potential) <= 0)
        begin
            res.status = wcts_pkg::ST_NOPOT;
            return res;
        end
        cur    = int'($signed(it.pixel_class));
        weight = {48'd0, it.potential};
        total  = '0;
        for (j = 0; j < n; j++)
        begin
            entry = prob_table[cur * wcts_pkg::MAX_CLASSES + j];
            // own class stays unweighted but is lifted to Q7.24 like the rest
            term  = (j == cur) ? {40'd0, entry, 8'd0} : {48'd0, entry} * weight;
            total = total + term;
            run_sum[j] = total;
        end
        // an all-zero row keeps the current class
        if (total != 0)
        begin
            scaled = {48'd0, it.random_value} * total;
            found  = 1'b0;
            for (j = 0; j < n && !found; j++)
            begin
                if (scaled <= (run_sum[j] << 16))
                begin
                    res.new_class = 16'(j);
                    found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // book an accepted beat: loads go into the table, pixels owe a result
    function automatic void absorb_item(input wcts_pkg::item_t it);
        int n;
        n = eff_classes();
        if (it.operation == wcts_pkg::OP_LOAD)
        begin
            if (it.src_class < n && it.dst_class < n)
                prob_table[{it.src_class, it.dst_class}] = it.probability;
        end
        else
            pending_results.push_back(predict_class(it));
    endfunction

    // ------------------------------------------------------------------
    // item builders and random draws
    // ------------------------------------------------------------------

    // every field random, so unused fields also toggle
    function automatic wcts_pkg::item_t rand_item();
        wcts_pkg::item_t it;
        it.operation    = 1'($urandom);
        it.src_class    = 4'($urandom);
        it.dst_class    = 4'($urandom);
        it.probability  = 16'($urandom);
        it.pixel_class  = 16'($urandom);
        it.potential    = 16'($urandom);
        it.random_value = 16'($urandom);
        return it;
    endfunction

    function automatic wcts_pkg::item_t make_load(input int f, input int t,
                                                  input logic [15:0] p);
        wcts_pkg::item_t it;
        it             = rand_item();
        it.operation   = wcts_pkg::OP_LOAD;
        it.src_class   = 4'(f);
        it.dst_class   = 4'(t);
        it.probability = p;
        return it;
    endfunction

    function automatic wcts_pkg::item_t make_pixel(input logic [15:0] cls,
                                                   input logic [15:0] pot,
                                                   input logic [15:0] rnd);
        wcts_pkg::item_t it;
        it              = rand_item();
        it.operation    = wcts_pkg::OP_PIXEL;
        it.pixel_class  = cls;
        it.potential    = pot;
        it.random_value = rnd;
        return it;
    endfunction

    // sparse rows and saturated entries are both worth hitting
    function automatic logic [15:0] rand_prob();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return 16'd0;
        else if (pick < 30)
            return 16'hffff;
        else if (pick < 50)
            return 16'($urandom_range(255, 1));
        else
            return 16'($urandom);
    endfunction

    // mostly usable weights, with some zero, negative and raw patterns
    function automatic logic [15:0] rand_potential();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 16'($urandom_range(32767, 1));
        else if (pick < 72)
            return 16'($urandom_range(1024, 1));
        else if (pick < 77)
            return 16'h0100;
        else if (pick < 86)
            return ($urandom_range(1) != 0) ? 16'd0 : (16'($urandom) | 16'h8000);
        else
            return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_draw();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 16'd0;
        else if (pick < 15)
            return 16'hffff;
        else
            return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------

    // one item beat; valid is left high on return so a following beat can
    // go out back to back without a dip
    task automatic send_item(input wcts_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_beat  <= it;
        do
            @(posedge clk);
        while (item_stall);
        absorb_item(it);
    endtask

    // hold the sender back until every owed result is in, then let the
    // block run dry, since loads leave nothing behind to wait for
    task automatic quiesce();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all three registers, back to back on the write channel
    task automatic configure(input int cls_count, input bit nd_en, input logic [15:0] nd_val);
        logic [wcts_pkg::CFG_IDX_W-1:0]  idx  [3];
        logic [wcts_pkg::CFG_DATA_W-1:0] vals [3];
        int                              i;
        idx[0]  = wcts_pkg::CFG_CLASS_COUNT;
        idx[1]  = wcts_pkg::CFG_NODATA_ENABLE;
        idx[2]  = wcts_pkg::CFG_NODATA_VALUE;
        vals[0] = 16'(cls_count);
        vals[1] = 16'(nd_en);
        vals[2] = nd_val;
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                wcts_pkg::CFG_CLASS_COUNT:
                    cur_class_count = vals[i][wcts_pkg::COUNT_W-1:0];
                wcts_pkg::CFG_NODATA_ENABLE:
                    cur_nodata_en   = vals[i][0];
                wcts_pkg::CFG_NODATA_VALUE:
                    cur_nodata_val  = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < REPORT_CAP)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // each drained result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", result_beat.new_class, '0);
            else
            begin
                head_result = pending_results.pop_front();
                if (result_beat.new_class !== head_result.new_class)
                    report_mismatch("new_class", result_beat.new_class, head_result.new_class);
                if (result_beat.status !== head_result.status)
                    report_mismatch("status", 16'(result_beat.status), 16'(head_result.status));
            end
        end
    end

    // hang detector: any accepted beat on any channel resets the count
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // straight out of reset: five classes, empty table, nodata off
    task automatic test_empty_table();
        send_item(make_pixel(16'd2, 16'h0100, 16'h8000));
        send_item(make_pixel(16'd4, 16'h7fff, 16'hffff));
        // matches the reset nodata value, but nodata is disabled
        send_item(make_pixel(16'd0, 16'h0001, 16'h0000));
        quiesce();
    endtask

    // widest table, extreme entries, weights, draws and class values
    task automatic test_field_extremes();
        configure(wcts_pkg::MAX_CLASSES, 1'b0, 16'h0000);
        send_item(make_load(15, 0, 16'h0000));
        send_item(make_load(15, 15, 16'hffff));
        send_item(make_load(15, 7, 16'hffff));
        send_item(make_load(0, 15, 16'h0001));
        // zero draw lands on the first column although its entry is zero
        send_item(make_pixel(16'd15, 16'h7fff, 16'h0000));
        send_item(make_pixel(16'd15, 16'h0001, 16'hffff));
        send_item(make_pixel(16'd15, 16'h0100, 16'h8000));
        send_item(make_pixel(16'd0, 16'h7fff, 16'hffff));
        // classes outside the table, both signs
        send_item(make_pixel(16'h8000, 16'h0100, 16'h1234));
        send_item(make_pixel(16'h7fff, 16'h0100, 16'h1234));
        send_item(make_pixel(16'd16, 16'h0100, 16'h1234));
        send_item(make_pixel(16'hffff, 16'h0100, 16'h1234));
        // no usable potential
        send_item(make_pixel(16'd3, 16'h8000, 16'h4000));
        send_item(make_pixel(16'd3, 16'h0000, 16'h4000));
        quiesce();
    endtask

    // nodata checked ahead of range and potential, smallest class count
    task automatic test_nodata_pass();
        configure(2, 1'b1, 16'h8000);
        send_item(make_pixel(16'h8000, 16'h0100, 16'h0000));
        send_item(make_pixel(16'd1, 16'h0000, 16'h0000));
        send_item(make_load(1, 0, 16'hffff));
        send_item(make_load(1, 1, 16'h0000));
        send_item(make_pixel(16'd1, 16'h7fff, 16'hffff));
        // row beyond the class count: must be dropped
        send_item(make_load(2, 0, 16'h0001));
        quiesce();
        // nodata value that is also a valid class
        configure(5, 1'b1, 16'd3);
        send_item(make_pixel(16'd3, 16'h0000, 16'h0000));
        send_item(make_pixel(16'd3, 16'h0100, 16'h8000));
        quiesce();
    endtask

    // mostly well-formed traffic: program a row, then sample it; the rest
    // is cleared rows, stray loads, nodata hits, raw and in-range pixels
    task automatic test_random_traffic(input int budget, input int cls_count);
        int              done;
        int              row;
        int              col;
        int              kind;
        wcts_pkg::item_t it;
        logic [15:0]     nd_val;
        nd_val = ($urandom_range(1) != 0) ? 16'($urandom_range(cls_count - 1))
                                          : 16'($urandom);
        configure(cls_count, 1'($urandom), nd_val);
        done = 0;
        while (done < budget)
        begin
            kind = $urandom_range(99);
            row  = $urandom_range(cls_count - 1);
            if (kind < 50)
            begin
                repeat ($urandom_range(cls_count, 1))
                begin
                    send_item(make_load(row, $urandom_range(cls_count - 1), rand_prob()));
                    done++;
                end
                repeat ($urandom_range(4, 1))
                begin
                    send_item(make_pixel(16'(row), rand_potential(), rand_draw()));
                    done++;
                end
            end
            else if (kind < 58)
            begin
                // zero the whole row: sampling it keeps the class
                for (col = 0; col < cls_count; col++)
                begin
                    send_item(make_load(row, col, 16'h0000));
                    done++;
                end
                send_item(make_pixel(16'(row), rand_potential(), rand_draw()));
                done++;
            end
            else if (kind < 72)
            begin
                it = make_load($urandom_range(15), $urandom_range(15), rand_prob());
                send_item(it);
                // dropped loads do not count towards the budget
                if (it.src_class < cls_count && it.dst_class < cls_count)
                    done++;
            end
            else if (kind < 80)
            begin
                send_item(make_pixel(nd_val, rand_potential(), rand_draw()));
                done++;
            end
            else if (kind < 90)
            begin
                send_item(make_pixel(16'($urandom), rand_potential(), rand_draw()));
                done++;
            end
            else
            begin
                send_item(make_pixel(16'($urandom_range(cls_count - 1)), rand_potential(),
                                     rand_draw()));
                done++;
            end
        end
        quiesce();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        int phase;
        int sub;
        int cls_count;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_field_extremes();
        test_nodata_pass();

        // idling: sender light / receiver heavy, then swapped, then none
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 27 : 0;
            for (sub = 0; sub < 4; sub++)
            begin
                cls_count = (sub == 0) ? 2
                          : (sub == 1) ? wcts_pkg::MAX_CLASSES
                          : $urandom_range(wcts_pkg::MAX_CLASSES - 1, 3);
                test_random_traffic(122, cls_count);
            end
        end

        quiesce();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
